/* hw/rtl/dnsae_pkg.sv */
// ----------------------------------------------------------------------------
// DNS answer address extractor package
// Shared result kinds, parse phases and the result and queue entry types.
// ----------------------------------------------------------------------------
package dnsae_pkg;

    localparam int HdrLen = 12;
    localparam logic [15:0] TypeA = 16'd1;
    localparam logic [15:0] TypeAaaa = 16'd28;
    localparam int QueueDepthDefault = 4;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_IPV4 = 3'd1,
        KIND_IPV6 = 3'd2,
        KIND_END_OK = 3'd3,
        KIND_END_ERR = 3'd4
    } kind_t;

    typedef enum logic [8:0] {
        PH_HEADER = 9'b000000001,
        PH_NAME = 9'b000000010,
        PH_LABEL = 9'b000000100,
        PH_PTR = 9'b000001000,
        PH_QFIX = 9'b000010000,
        PH_AFIX = 9'b000100000,
        PH_RDATA = 9'b001000000,
        PH_DONE = 9'b010000000,
        PH_ERROR = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic        done_res;
        logic [63:0] addr_low;
        logic [63:0] addr_high;
        logic [31:0] time_to_live;
        logic [15:0] record_count;
        logic [3:0]  rcode_value;
        logic [6:0]  header_flags;
        logic [3:0]  opcode_value;
        logic        is_response;
        logic [15:0] message_id;
        logic [2:0]  result_kind;
    } result_t;

    localparam int ResultW = $bits(result_t);
    // The result kind travels on tuser and the done flag on tlast.
    localparam int TdataW = ((ResultW - 4 + 7) / 8) * 8;

    // Front output for one byte: up to two results.
    typedef struct packed {
        logic    first_valid;
        result_t first;
        logic    second_valid;
        result_t second;
    } entry_t;

endpackage

/* hw/rtl/dns_answer_address_extractor.sv */
// ----------------------------------------------------------------------------
// DNS answer address extractor
// Parses a DNS response byte stream and reports header, addresses and end.
//
// Channel | Direction | tdata                   | tuser       | tlast
// s_      | in        | data_byte[7:0]          | none        | end_of_message
// m_      | out       | result fields, see port | result_kind | done_res
//
// One byte is taken every cycle while the result queue has room for two
// results. A result enters the queue as its byte is taken and is offered
// once earlier results have left; results leave at one per cycle while
// m_tready is high. Reset is synchronous and clears the parse state and
// queue. A result-side stall backs up into the queue, then holds s_tready low.
// ----------------------------------------------------------------------------
module dns_answer_address_extractor #(
    parameter int QueueDepth = dnsae_pkg::QueueDepthDefault
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // data_byte[7:0]
    input  logic [7:0]                    s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // message_id, is_response, opcode_value, header_flags, rcode_value,
    // record_count, time_to_live, addr_high, addr_low
    output logic [dnsae_pkg::TdataW-1:0]  m_tdata,
    // result_kind[2:0]
    output logic [2:0]                    m_tuser,
    output logic                          m_tlast
);

    dnsae_pkg::entry_t entry;
    dnsae_pkg::result_t res;
    logic room;

    assign s_tready = room;

    dnsae_parser u_parser (
        .aclk(aclk),
        .aresetn(aresetn),
        .byte_valid(s_tvalid && room),
        .data_byte(s_tdata),
        .end_of_message(s_tlast),
        .entry(entry)
    );

    dnsae_queue #(.Depth(QueueDepth)) u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .entry(entry),
        .room(room),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data(res)
    );

    assign m_tdata = dnsae_pkg::TdataW'({res.addr_low, res.addr_high, res.time_to_live,
                                         res.record_count, res.rcode_value,
                                         res.header_flags, res.opcode_value,
                                         res.is_response, res.message_id});
    assign m_tuser = res.result_kind;
    assign m_tlast = res.done_res;

endmodule

/* hw/rtl/dnsae_parser.sv */
// ----------------------------------------------------------------------------
// DNS answer address extractor front end
// Walks the message one byte per valid cycle and gives each byte's results.
// ----------------------------------------------------------------------------
module dnsae_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_valid,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_message,
    output dnsae_pkg::entry_t    entry
);

    dnsae_pkg::phase_t phase_reg, phase_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [31:0] hdr_reg, hdr_next;
    logic [15:0] qleft_reg, qleft_next;
    logic [15:0] aleft_reg, aleft_next;
    logic [5:0]  lleft_reg, lleft_next;
    logic [15:0] rtype_reg, rtype_next;
    logic [31:0] ttl_reg, ttl_next;
    logic [15:0] rleft_reg, rleft_next;
    logic [63:0] sh0_reg, sh0_next, sh1_reg, sh1_next;
    logic [15:0] found_reg, found_next;
    dnsae_pkg::result_t r;
    dnsae_pkg::result_t e;
    logic r_valid;
    logic v4, v6;
    logic [15:0] cinc;

    always_comb begin
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        hdr_next = hdr_reg;
        qleft_next = qleft_reg;
        aleft_next = aleft_reg;
        lleft_next = lleft_reg;
        rtype_next = rtype_reg;
        ttl_next = ttl_reg;
        rleft_next = rleft_reg;
        sh0_next = sh0_reg;
        sh1_next = sh1_reg;
        found_next = found_reg;
        r = '0;
        r_valid = 1'b0;
        e = '0;
        v4 = 1'b0;
        v6 = 1'b0;
        cinc = cnt_reg + 16'd1;
        case (phase_reg)
            dnsae_pkg::PH_HEADER: begin
                if (cnt_reg < 16'd4) begin
                    hdr_next = {hdr_reg[23:0], data_byte};
                end else if (cnt_reg < 16'd6) begin
                    qleft_next = {qleft_reg[7:0], data_byte};
                end else if (cnt_reg < 16'd8) begin
                    aleft_next = {aleft_reg[7:0], data_byte};
                end
                cnt_next = cinc;
                if (cinc >= 16'(dnsae_pkg::HdrLen)) begin
                    r_valid = 1'b1;
                    r.result_kind = dnsae_pkg::KIND_HEADER;
                    r.message_id = hdr_next[31:16];
                    r.is_response = hdr_next[15];
                    r.opcode_value = hdr_next[14:11];
                    r.header_flags = {hdr_next[10:8], hdr_next[7:4]};
                    r.rcode_value = hdr_next[3:0];
                    r.record_count = aleft_next;
                    cnt_next = '0;
                    phase_next = (qleft_next != 0 || aleft_next != 0) ?
                        dnsae_pkg::PH_NAME : dnsae_pkg::PH_DONE;
                end
            end
            dnsae_pkg::PH_NAME: begin
                if (data_byte == 8'd0) begin
                    cnt_next = '0;
                    phase_next = (qleft_reg != 0) ? dnsae_pkg::PH_QFIX
                                                  : dnsae_pkg::PH_AFIX;
                end else if (data_byte[7:6] == 2'b11) begin
                    phase_next = dnsae_pkg::PH_PTR;
                end else if (data_byte[7:6] != 2'b00) begin
                    phase_next = dnsae_pkg::PH_ERROR;
                end else begin
                    lleft_next = data_byte[5:0];
                    phase_next = dnsae_pkg::PH_LABEL;
                end
            end
            dnsae_pkg::PH_LABEL: begin
                lleft_next = lleft_reg - 6'd1;
                if (lleft_next == 6'd0) begin
                    phase_next = dnsae_pkg::PH_NAME;
                end
            end
            dnsae_pkg::PH_PTR: begin
                cnt_next = '0;
                phase_next = (qleft_reg != 0) ? dnsae_pkg::PH_QFIX
                                              : dnsae_pkg::PH_AFIX;
            end
            dnsae_pkg::PH_QFIX: begin
                cnt_next = cinc;
                if (cinc >= 16'd4) begin
                    qleft_next = qleft_reg - 16'd1;
                    cnt_next = '0;
                    phase_next = (qleft_next != 0 || aleft_reg != 0) ?
                        dnsae_pkg::PH_NAME : dnsae_pkg::PH_DONE;
                end
            end
            dnsae_pkg::PH_AFIX: begin
                if (cnt_reg < 16'd2) begin
                    rtype_next = {rtype_reg[7:0], data_byte};
                end else if (cnt_reg >= 16'd4 && cnt_reg < 16'd8) begin
                    ttl_next = {ttl_reg[23:0], data_byte};
                end else if (cnt_reg >= 16'd8) begin
                    rleft_next = {rleft_reg[7:0], data_byte};
                end
                cnt_next = cinc;
                if (cinc >= 16'd10) begin
                    cnt_next = '0;
                    sh0_next = '0;
                    sh1_next = '0;
                    if (rleft_next == 16'd0) begin
                        aleft_next = aleft_reg - 16'd1;
                        phase_next = (qleft_reg != 0 || aleft_next != 0) ?
                            dnsae_pkg::PH_NAME : dnsae_pkg::PH_DONE;
                    end else begin
                        phase_next = dnsae_pkg::PH_RDATA;
                    end
                end
            end
            dnsae_pkg::PH_RDATA: begin
                sh0_next = {sh0_reg[55:0], sh1_reg[63:56]};
                sh1_next = {sh1_reg[55:0], data_byte};
                cnt_next = cinc;
                rleft_next = rleft_reg - 16'd1;
                if (rleft_next == 16'd0) begin
                    v4 = rtype_reg == dnsae_pkg::TypeA && cinc == 16'd4;
                    v6 = rtype_reg == dnsae_pkg::TypeAaaa && cinc == 16'd16;
                    if (v4 || v6) begin
                        r_valid = 1'b1;
                        r.result_kind = v4 ? dnsae_pkg::KIND_IPV4
                                           : dnsae_pkg::KIND_IPV6;
                        r.time_to_live = ttl_reg;
                        r.addr_high = v4 ? 64'd0 : sh0_next;
                        r.addr_low = v4 ? {32'd0, sh1_next[31:0]} : sh1_next;
                        found_next = found_reg + 16'd1;
                    end
                    cnt_next = '0;
                    aleft_next = aleft_reg - 16'd1;
                    phase_next = (qleft_reg != 0 || aleft_next != 0) ?
                        dnsae_pkg::PH_NAME : dnsae_pkg::PH_DONE;
                end
            end
            default: begin
            end
        endcase
        e.result_kind = (phase_next == dnsae_pkg::PH_DONE) ?
            dnsae_pkg::KIND_END_OK : dnsae_pkg::KIND_END_ERR;
        e.record_count = found_next;
        e.done_res = 1'b1;
        entry.first_valid = byte_valid && (r_valid || end_of_message);
        entry.first = r_valid ? r : e;
        entry.second_valid = byte_valid && r_valid && end_of_message;
        entry.second = e;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_valid && end_of_message)) begin
            phase_reg <= dnsae_pkg::PH_HEADER;
            cnt_reg <= '0;
            hdr_reg <= '0;
            qleft_reg <= '0;
            aleft_reg <= '0;
            lleft_reg <= '0;
            rtype_reg <= '0;
            ttl_reg <= '0;
            rleft_reg <= '0;
            sh0_reg <= '0;
            sh1_reg <= '0;
            found_reg <= '0;
        end else if (byte_valid) begin
            phase_reg <= phase_next;
            cnt_reg <= cnt_next;
            hdr_reg <= hdr_next;
            qleft_reg <= qleft_next;
            aleft_reg <= aleft_next;
            lleft_reg <= lleft_next;
            rtype_reg <= rtype_next;
            ttl_reg <= ttl_next;
            rleft_reg <= rleft_next;
            sh0_reg <= sh0_next;
            sh1_reg <= sh1_next;
            found_reg <= found_next;
        end
    end

endmodule

/* hw/rtl/dnsae_queue.sv */
// ----------------------------------------------------------------------------
// DNS answer address extractor result queue
// Holds results between parser and output; drains one a cycle on out_ready.
// ----------------------------------------------------------------------------
module dnsae_queue #(
    parameter int Depth = dnsae_pkg::QueueDepthDefault
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dnsae_pkg::entry_t     entry,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dnsae_pkg::result_t    out_data
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    dnsae_pkg::result_t mem_reg [Depth];
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0] cnt_reg, cnt_next;
    logic [AW-1:0] wp1;
    logic pop;
    logic [1:0] pushes;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
    endfunction

    assign out_valid = cnt_reg != '0;
    assign out_data = mem_reg[rp_reg];
    assign pop = out_valid && out_ready;
    assign room = cnt_reg <= (AW + 1)'(Depth - 2);
    assign wp1 = inc(wp_reg);
    assign pushes = {1'b0, entry.first_valid} + {1'b0, entry.second_valid};

    always_comb begin
        wp_next = wp_reg;
        if (pushes == 2'd1) begin
            wp_next = wp1;
        end else if (pushes == 2'd2) begin
            wp_next = inc(wp1);
        end
        rp_next = pop ? inc(rp_reg) : rp_reg;
        cnt_next = cnt_reg + (AW + 1)'(pushes) - (AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (entry.first_valid) begin
            mem_reg[wp_reg] <= entry.first;
        end
        if (entry.second_valid) begin
            mem_reg[wp1] <= entry.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* hw/rtl/dnsae_checker.sv */
// ----------------------------------------------------------------------------
// DNS answer address extractor checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module dnsae_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [dnsae_pkg::TdataW-1:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed under stall");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= dnsae_pkg::KIND_END_ERR)
        else $error("bad result kind");

    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == dnsae_pkg::KIND_END_OK ||
                                  m_tuser == dnsae_pkg::KIND_END_ERR)))
        else $error("done flag does not match end result");

    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after the final byte");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");

endmodule

bind dns_answer_address_extractor dnsae_checker u_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
);
